[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the burn-wire sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BWDS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bwds assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BWDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bwds assertion failed");

`endif

[hw/rtl/bwds_pkg.sv]
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer package
// Types, register codes and helper functions shared by the sequencer files.
// ----------------------------------------------------------------------------
package bwds_pkg;

   localparam int FACE_COUNT = 4;

   // Opcodes of a request.
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_BURN = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_ATTEMPTS = 2'd0;
   localparam logic [1:0] CSR_BURN_TICKS   = 2'd1;
   localparam logic [1:0] CSR_OFF_TICKS    = 2'd2;

   // Register reset values.
   localparam logic [7:0]  MAX_ATTEMPTS_RESET = 8'd5;
   localparam logic [15:0] BURN_TICKS_RESET   = 16'd20;
   localparam logic [15:0] OFF_TICKS_RESET    = 16'd10;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_BURN = 2'd1,
      PH_OFF  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]  max_attempts;
      logic [15:0] burn_ticks;
      logic [15:0] off_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] face;
      logic [3:0] switch_states;
   } req_item_type;

   typedef struct packed {
      logic [FACE_COUNT-1:0] heater_drive;
      logic                  busy_res;
      logic                  reply_valid;
      logic [2:0]            reply_face;
      logic                  reply_switch;
      logic                  sequence_done;
      logic [7:0]            attempt_index;
   } rsp_item_type;

   // Switch of a face code; codes outside one to four read as open.
   function automatic logic face_bit(input logic [2:0] face, input logic [3:0] sw);
      logic bit_val;
      unique case (face)
         3'd1:    bit_val = sw[0];
         3'd2:    bit_val = sw[1];
         3'd3:    bit_val = sw[2];
         3'd4:    bit_val = sw[3];
         default: bit_val = 1'b0;
      endcase
      return bit_val;
   endfunction

endpackage

[hw/rtl/bwds_channels.sv]
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface bwds_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [2:0] face;
   logic [3:0] switch_states;

   modport source (output valid, output opcode, output face, output switch_states,
                   input ready);
   modport sink (input valid, input opcode, input face, input switch_states,
                 output ready);
endinterface

interface bwds_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] heater_drive;
   logic       busy_res;
   logic       reply_valid;
   logic [2:0] reply_face;
   logic       reply_switch;
   logic       sequence_done;
   logic [7:0] attempt_index;

   modport source (output valid, output heater_drive, output busy_res,
                   output reply_valid, output reply_face, output reply_switch,
                   output sequence_done, output attempt_index, input ready);
   modport sink (input valid, input heater_drive, input busy_res,
                 input reply_valid, input reply_face, input reply_switch,
                 input sequence_done, input attempt_index, output ready);
endinterface

[hw/rtl/burn_wire_deploy_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer core
// Four-face burn-wire release sequencer with one response per request.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Moves
//   req_chan   in         one request: opcode, face, switch sample
//   rsp_chan   out        one response: heater, status, read reply
//   csr_*      in         register write: enable, index, data
//
// One request is taken every cycle while req_chan.ready is high; its response
// passes through the input register and then the result register.
// Reset clears the sequence state and loads the register defaults.
// A stalled response holds; the input register keeps taking requests
// until both stages are full, then req_chan.ready drops.
//
module burn_wire_deploy_sequencer_core (
   input  logic         clock,
   input  logic         reset,
   bwds_req_if.sink     req_chan,
   bwds_rsp_if.source   rsp_chan,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   bwds_pkg::cfg_type      cfg;
   bwds_pkg::req_item_type in_item_ff;
   logic                   in_valid_ff;
   bwds_pkg::rsp_item_type out_item_ff;
   bwds_pkg::rsp_item_type out_item_in;
   logic                   out_valid_ff;
   logic                   out_load;
   logic                   in_load;

   bwds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bwds_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (out_load),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (out_item_in)
   );

   // Stage handshakes.
   assign out_load       = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || out_load;
   assign in_load        = req_chan.valid && req_chan.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_item_ff.opcode        <= req_chan.opcode;
         in_item_ff.face          <= req_chan.face;
         in_item_ff.switch_states <= req_chan.switch_states;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.heater_drive  = out_item_ff.heater_drive;
   assign rsp_chan.busy_res      = out_item_ff.busy_res;
   assign rsp_chan.reply_valid   = out_item_ff.reply_valid;
   assign rsp_chan.reply_face    = out_item_ff.reply_face;
   assign rsp_chan.reply_switch  = out_item_ff.reply_switch;
   assign rsp_chan.sequence_done = out_item_ff.sequence_done;
   assign rsp_chan.attempt_index = out_item_ff.attempt_index;

endmodule

[hw/rtl/bwds_csr.sv]
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer registers
// Write-only configuration registers with their reset values.
// ----------------------------------------------------------------------------
module bwds_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output bwds_pkg::cfg_type cfg
);

   bwds_pkg::cfg_type cfg_ff;
   bwds_pkg::cfg_type cfg_in;

   // Decode the write; an index past the list leaves everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bwds_pkg::CSR_MAX_ATTEMPTS: cfg_in.max_attempts = csr_wdata[7:0];
            bwds_pkg::CSR_BURN_TICKS:   cfg_in.burn_ticks   = csr_wdata;
            bwds_pkg::CSR_OFF_TICKS:    cfg_in.off_ticks    = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts <= bwds_pkg::MAX_ATTEMPTS_RESET;
         cfg_ff.burn_ticks   <= bwds_pkg::BURN_TICKS_RESET;
         cfg_ff.off_ticks    <= bwds_pkg::OFF_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/bwds_engine.sv]
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer engine
// Sequence state registers and the single-pass update for one request.
// ----------------------------------------------------------------------------
module bwds_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  bwds_pkg::req_item_type item,
   input  bwds_pkg::cfg_type      cfg,
   output bwds_pkg::rsp_item_type result
);

   bwds_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          burn_face_ff, burn_face_in;
   logic [15:0]         tick_count_ff, tick_count_in;
   logic [7:0]          attempt_count_ff, attempt_count_in;
   logic                stop_pending_ff, stop_pending_in;

   logic        cur_sw;
   logic [16:0] tick_next;
   logic [8:0]  attempt_next;
   logic        finish;
   logic        done;

   assign cur_sw       = item.switch_states[burn_face_ff];
   assign tick_next    = {1'b0, tick_count_ff} + 17'd1;
   assign attempt_next = {1'b0, attempt_count_ff} + 9'd1;

   // Next state for one request.
   always_comb begin
      phase_in         = phase_ff;
      burn_face_in     = burn_face_ff;
      tick_count_in    = tick_count_ff;
      attempt_count_in = attempt_count_ff;
      stop_pending_in  = stop_pending_ff;
      finish           = 1'b0;
      done             = 1'b0;

      if (item.opcode == bwds_pkg::OP_BURN) begin
         if (phase_ff == bwds_pkg::PH_IDLE &&
             bwds_pkg::face_bit(item.face, item.switch_states)) begin
            if (cfg.max_attempts == 8'd0) begin
               done = 1'b1;
            end else begin
               burn_face_in     = 2'(item.face - 3'd1);
               phase_in         = bwds_pkg::PH_BURN;
               tick_count_in    = 16'd0;
               attempt_count_in = 8'd0;
               stop_pending_in  = 1'b0;
            end
         end
      end else if (item.opcode == bwds_pkg::OP_TICK) begin
         unique case (phase_ff)
            bwds_pkg::PH_BURN: begin
               // A zero burn length acts as one since the count starts at one.
               if (tick_next >= {1'b0, cfg.burn_ticks} || !cur_sw) begin
                  stop_pending_in = !cur_sw;
                  phase_in        = bwds_pkg::PH_OFF;
                  tick_count_in   = 16'd0;
                  finish          = (cfg.off_ticks == 16'd0);
               end else begin
                  tick_count_in = tick_next[15:0];
               end
            end
            bwds_pkg::PH_OFF: begin
               if (tick_next >= {1'b0, cfg.off_ticks}) begin
                  tick_count_in = 16'd0;
                  finish        = 1'b1;
               end else begin
                  tick_count_in = tick_next[15:0];
               end
            end
            default: begin
               phase_in = bwds_pkg::PH_IDLE;
            end
         endcase
      end

      // End of an off phase, or of a burn phase when the off length is zero: stop or start the next attempt.
      if (finish) begin
         tick_count_in = 16'd0;
         if (stop_pending_in || attempt_next >= {1'b0, cfg.max_attempts}) begin
            phase_in         = bwds_pkg::PH_IDLE;
            attempt_count_in = 8'd0;
            stop_pending_in  = 1'b0;
            done             = 1'b1;
         end else begin
            attempt_count_in = attempt_next[7:0];
            phase_in         = bwds_pkg::PH_BURN;
         end
      end
   end

   // Result fields follow the state after this request.
   always_comb begin
      result.heater_drive  = (phase_in == bwds_pkg::PH_BURN) ?
                             (4'd1 << burn_face_in) : 4'd0;
      result.busy_res      = (phase_in != bwds_pkg::PH_IDLE);
      result.reply_valid   = (item.opcode == bwds_pkg::OP_READ);
      result.reply_face    = (item.opcode == bwds_pkg::OP_READ) ? item.face : 3'd0;
      result.reply_switch  = (item.opcode == bwds_pkg::OP_READ) &&
                             bwds_pkg::face_bit(item.face, item.switch_states);
      result.sequence_done = done;
      result.attempt_index = (phase_in != bwds_pkg::PH_IDLE) ? attempt_count_in : 8'd0;
   end

   // State registers advance only when the request moves to the result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= bwds_pkg::PH_IDLE;
         burn_face_ff     <= 2'd0;
         tick_count_ff    <= 16'd0;
         attempt_count_ff <= 8'd0;
         stop_pending_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         burn_face_ff     <= burn_face_in;
         tick_count_ff    <= tick_count_in;
         attempt_count_ff <= attempt_count_in;
         stop_pending_ff  <= stop_pending_in;
      end
   end

endmodule

[hw/rtl/bwds_checker.sv]
// ----------------------------------------------------------------------------
// Burn-wire deploy sequencer checker
// Port-level assertions on the response channel, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwds_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] heater_drive,
   input logic       busy_res,
   input logic       reply_valid,
   input logic [2:0] reply_face,
   input logic       reply_switch,
   input logic       sequence_done,
   input logic [7:0] attempt_index
);

   // At most one heater, and only while a sequence runs.
   `BWDS_ASSERT_IMPL(heater_single, rsp_valid, $onehot0(heater_drive))
   `BWDS_ASSERT_IMPL(heater_needs_busy, rsp_valid && heater_drive != 4'd0, busy_res)

   // A finished sequence leaves the block idle with a cleared attempt count.
   `BWDS_ASSERT_IMPL(done_is_idle, rsp_valid && sequence_done,
                     !busy_res && attempt_index == 8'd0)

   // Reply fields are zero on anything but a switch read.
   `BWDS_ASSERT_IMPL(reply_quiet, rsp_valid && !reply_valid,
                     reply_face == 3'd0 && !reply_switch)

   // A stalled response holds its payload.
   `BWDS_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable({heater_drive, busy_res, reply_valid, reply_face,
                                           reply_switch, sequence_done, attempt_index}))

endmodule

bind burn_wire_deploy_sequencer_core bwds_checker u_bwds_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .heater_drive  (rsp_chan.heater_drive),
   .busy_res      (rsp_chan.busy_res),
   .reply_valid   (rsp_chan.reply_valid),
   .reply_face    (rsp_chan.reply_face),
   .reply_switch  (rsp_chan.reply_switch),
   .sequence_done (rsp_chan.sequence_done),
   .attempt_index (rsp_chan.attempt_index)
);
